[sv/hpt_pkg.sv]
// shared constants and types for the homogeneous point transform
package hpt_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int NUM_REGS      = 8;
  localparam int REG_W         = 64;
  localparam int IDX_W         = 3;
  localparam int DW            = 32;
  localparam int QBITS         = 32;

  // matrix entries, [row][col] of signed fixed point words
  typedef logic [3:0][3:0][DW-1:0] mat_t;

  // per-request control that rides along the divider
  typedef struct packed {
    logic       dir;
    logic       wz;
    logic       sat_d;
    logic [2:0] neg;
    logic [2:0] ovf;
  } ctl_t;

endpackage

[sv/hpt_mac.sv]
// input register, 12 products and the four column sums
module hpt_mac #(
  parameter int FRAC_BITS = hpt_pkg::FRAC_BITS_DEF,
  parameter int AW        = 66 - FRAC_BITS
) (
  input  logic                        clk,
  input  logic [2:0]                  en,
  input  logic signed [hpt_pkg::DW-1:0] x_i,
  input  logic signed [hpt_pkg::DW-1:0] y_i,
  input  logic signed [hpt_pkg::DW-1:0] z_i,
  input  logic                        dir_i,
  input  hpt_pkg::mat_t               mat,
  output logic signed [AW-1:0]        acc_o [4],
  output logic                        dir_o
);

  localparam int PW = 2 * hpt_pkg::DW - FRAC_BITS;

  logic signed [hpt_pkg::DW-1:0] v_r [3];
  logic                          dir0_r, dir1_r, dir2_r;
  logic signed [2*hpt_pkg::DW-1:0] prod [3][4];
  logic signed [PW-1:0]          p_r [3][4];
  logic signed [AW-1:0]          acc_nxt [4];
  logic signed [AW-1:0]          acc_r [4];

  // stage 0: input capture
  always_ff @(posedge clk) begin
    if (en[0]) begin
      v_r[0] <= x_i;
      v_r[1] <= y_i;
      v_r[2] <= z_i;
      dir0_r <= dir_i;
    end
  end

  // stage 1: products, floored by the fraction shift
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 4; j++) begin
        prod[i][j] = v_r[i] * $signed(mat[i][j]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 4; j++) begin
          p_r[i][j] <= prod[i][j][2*hpt_pkg::DW-1:FRAC_BITS];
        end
      end
      dir1_r <= dir0_r;
    end
  end

  // stage 2: column sums, translation only for points
  always_comb begin
    for (int j = 0; j < 4; j++) begin
      acc_nxt[j] = AW'(p_r[0][j]) + AW'(p_r[1][j]) + AW'(p_r[2][j]) +
                   (dir1_r ? '0 : AW'($signed(mat[3][j])));
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      acc_r  <= acc_nxt;
      dir2_r <= dir1_r;
    end
  end

  assign acc_o = acc_r;
  assign dir_o = dir2_r;

endmodule

[sv/hpt_prep.sv]
// sign split, w test, direction clamp and divider setup
module hpt_prep #(
  parameter int FRAC_BITS = hpt_pkg::FRAC_BITS_DEF,
  parameter int AW        = 66 - FRAC_BITS
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [AW-1:0]          acc_i [4],
  input  logic                          dir_i,
  output hpt_pkg::ctl_t                 ctl_o,
  output logic [2:0][AW-1:0]            r_o,
  output logic [2:0][hpt_pkg::QBITS-1:0] nq_o,
  output logic [AW-1:0]                 ad_o,
  output logic [2:0][hpt_pkg::DW-1:0]   byp_o
);

  localparam int NW = AW + FRAC_BITS;
  localparam int HW = NW - hpt_pkg::QBITS;

  hpt_pkg::ctl_t                  ctl_nxt, ctl_r;
  logic [2:0][AW-1:0]             r_nxt, r_r;
  logic [2:0][hpt_pkg::QBITS-1:0] nq_nxt, nq_r;
  logic [2:0][hpt_pkg::DW-1:0]    byp_nxt, byp_r;
  logic [AW-1:0]                  ad_nxt, ad_r;
  logic [AW-1:0]                  an;
  logic [NW-1:0]                  num;
  logic [HW-1:0]                  hi;
  logic                           big;

  always_comb begin
    ctl_nxt       = '0;
    ctl_nxt.dir   = dir_i;
    ctl_nxt.wz    = !dir_i && (acc_i[3] == '0);
    ad_nxt        = acc_i[3][AW-1] ? (~acc_i[3] + 1'b1) : acc_i[3];
    an            = '0;
    num           = '0;
    hi            = '0;
    big           = 1'b0;
    for (int j = 0; j < 3; j++) begin
      // direction path: clamp to 32 bits signed
      big = (acc_i[j][AW-1:hpt_pkg::DW-1] != '0) &&
            (acc_i[j][AW-1:hpt_pkg::DW-1] != '1);
      if (big) begin
        byp_nxt[j] = acc_i[j][AW-1] ? {1'b1, {(hpt_pkg::DW-1){1'b0}}}
                                    : {1'b0, {(hpt_pkg::DW-1){1'b1}}};
        if (dir_i) ctl_nxt.sat_d = 1'b1;
      end else begin
        byp_nxt[j] = acc_i[j][hpt_pkg::DW-1:0];
      end
      // point path: magnitude shifted up, high part seeds the remainder
      an             = acc_i[j][AW-1] ? (~acc_i[j] + 1'b1) : acc_i[j];
      num            = {an, {FRAC_BITS{1'b0}}};
      hi             = num[NW-1:hpt_pkg::QBITS];
      ctl_nxt.ovf[j] = AW'(hi) >= ad_nxt;
      ctl_nxt.neg[j] = acc_i[j][AW-1] ^ acc_i[3][AW-1];
      r_nxt[j]       = AW'(hi);
      nq_nxt[j]      = num[hpt_pkg::QBITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl_r <= ctl_nxt;
      r_r   <= r_nxt;
      nq_r  <= nq_nxt;
      ad_r  <= ad_nxt;
      byp_r <= byp_nxt;
    end
  end

  assign ctl_o = ctl_r;
  assign r_o   = r_r;
  assign nq_o  = nq_r;
  assign ad_o  = ad_r;
  assign byp_o = byp_r;

endmodule

[sv/hpt_div_step.sv]
// one restoring division step for the three lanes, registered
module hpt_div_step #(
  parameter int AW = 50
) (
  input  logic                           clk,
  input  logic                           en,
  input  hpt_pkg::ctl_t                  ctl_i,
  input  logic [2:0][AW-1:0]             r_i,
  input  logic [2:0][hpt_pkg::QBITS-1:0] nq_i,
  input  logic [AW-1:0]                  ad_i,
  input  logic [2:0][hpt_pkg::DW-1:0]    byp_i,
  output hpt_pkg::ctl_t                  ctl_o,
  output logic [2:0][AW-1:0]             r_o,
  output logic [2:0][hpt_pkg::QBITS-1:0] nq_o,
  output logic [AW-1:0]                  ad_o,
  output logic [2:0][hpt_pkg::DW-1:0]    byp_o
);

  logic [2:0][AW-1:0]             r_nxt;
  logic [2:0][hpt_pkg::QBITS-1:0] nq_nxt;
  logic [AW:0]                    rs [3];
  logic [AW:0]                    diff [3];

  // trial subtract, keep the remainder when it goes negative
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      rs[j]     = {r_i[j], nq_i[j][hpt_pkg::QBITS-1]};
      diff[j]   = rs[j] - {1'b0, ad_i};
      r_nxt[j]  = diff[j][AW] ? rs[j][AW-1:0] : diff[j][AW-1:0];
      nq_nxt[j] = {nq_i[j][hpt_pkg::QBITS-2:0], ~diff[j][AW]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl_o <= ctl_i;
      r_o   <= r_nxt;
      nq_o  <= nq_nxt;
      ad_o  <= ad_i;
      byp_o <= byp_i;
    end
  end

endmodule

[sv/homogeneous_point_transform_top.sv]
// homogeneous point transform: 4x4 matrix multiply with perspective divide
//
// Usage: load the matrix through cfg_we/cfg_index/cfg_data while idle; each
// cfg_index holds two signed fixed point entries of one row (low word = even
// column). Reset loads the identity matrix and empties the pipeline.
// Requests enter on in_valid/in_ready with x, y, z and in_is_direction;
// results leave on out_valid/out_ready with x, y, z and the w_zero and
// saturated flags, one result per request, in order.
// Each request passes 37 registers in order from the accepting edge to
// out_valid: input register, product stage, sum stage, setup stage, 32
// restoring divider stages (one quotient bit per stage) and the output
// register. Throughput is one request per cycle while out_ready stays high.
// Directions also pass the divider stages, with their result held aside.
// When the receiver stalls, each stage holds only while the stage after it
// is full, so bubbles close up and in_ready stays high until the pipeline
// is full; nothing is dropped or repeated.
module homogeneous_point_transform_top #(
  parameter int FRAC_BITS = hpt_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [hpt_pkg::IDX_W-1:0]     cfg_index,
  input  logic [hpt_pkg::REG_W-1:0]     cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [hpt_pkg::DW-1:0] in_x,
  input  logic signed [hpt_pkg::DW-1:0] in_y,
  input  logic signed [hpt_pkg::DW-1:0] in_z,
  input  logic                          in_is_direction,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [hpt_pkg::DW-1:0] out_x,
  output logic signed [hpt_pkg::DW-1:0] out_y,
  output logic signed [hpt_pkg::DW-1:0] out_z,
  output logic                          out_w_zero,
  output logic                          out_saturated
);

  localparam int AW  = 66 - FRAC_BITS;
  localparam int QB  = hpt_pkg::QBITS;
  localparam int NST = 4 + QB + 1;
  localparam logic [hpt_pkg::REG_W-1:0] ONE = hpt_pkg::REG_W'(1) << FRAC_BITS;

  logic [hpt_pkg::REG_W-1:0] cfg_r [hpt_pkg::NUM_REGS];
  hpt_pkg::mat_t             mat;
  logic [NST-1:0]            v_r;
  logic [NST-1:0]            en;

  logic signed [AW-1:0]      acc [4];
  logic                      dir_m;

  hpt_pkg::ctl_t                  ctl_s [QB+1];
  logic [2:0][AW-1:0]             r_s   [QB+1];
  logic [2:0][QB-1:0]             nq_s  [QB+1];
  logic [AW-1:0]                  ad_s  [QB+1];
  logic [2:0][hpt_pkg::DW-1:0]    byp_s [QB+1];

  logic [2:0][hpt_pkg::DW-1:0]    res_nxt, res_r;
  logic                           wz_r, sat_nxt, sat_r;
  logic                           lsat;
  hpt_pkg::ctl_t                  cf;

  // configuration registers, reset to identity
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r[0] <= ONE;
      cfg_r[1] <= '0;
      cfg_r[2] <= ONE << hpt_pkg::DW;
      cfg_r[3] <= '0;
      cfg_r[4] <= '0;
      cfg_r[5] <= ONE;
      cfg_r[6] <= '0;
      cfg_r[7] <= ONE << hpt_pkg::DW;
    end else if (cfg_we) begin
      cfg_r[cfg_index] <= cfg_data;
    end
  end

  // unpack registers into matrix entries
  for (genvar r = 0; r < 4; r++) begin : g_row
    for (genvar c = 0; c < 4; c++) begin : g_col
      assign mat[r][c] = cfg_r[r*2 + c/2][(c%2)*hpt_pkg::DW +: hpt_pkg::DW];
    end
  end

  // stage enables: a stage moves when empty or when its successor moves
  assign en[NST-1] = !v_r[NST-1] || out_ready;
  for (genvar k = 0; k < NST-1; k++) begin : g_en
    assign en[k] = !v_r[k] || en[k+1];
  end
  assign in_ready = en[0];

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_valid;
      for (int k = 1; k < NST; k++) begin
        if (en[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  hpt_mac #(.FRAC_BITS(FRAC_BITS), .AW(AW)) u_mac (
    .clk   (clk),
    .en    (en[2:0]),
    .x_i   (in_x),
    .y_i   (in_y),
    .z_i   (in_z),
    .dir_i (in_is_direction),
    .mat   (mat),
    .acc_o (acc),
    .dir_o (dir_m)
  );

  hpt_prep #(.FRAC_BITS(FRAC_BITS), .AW(AW)) u_prep (
    .clk   (clk),
    .en    (en[3]),
    .acc_i (acc),
    .dir_i (dir_m),
    .ctl_o (ctl_s[0]),
    .r_o   (r_s[0]),
    .nq_o  (nq_s[0]),
    .ad_o  (ad_s[0]),
    .byp_o (byp_s[0])
  );

  // divider chain, one quotient bit per stage
  for (genvar s = 0; s < QB; s++) begin : g_div
    hpt_div_step #(.AW(AW)) u_step (
      .clk   (clk),
      .en    (en[4+s]),
      .ctl_i (ctl_s[s]),
      .r_i   (r_s[s]),
      .nq_i  (nq_s[s]),
      .ad_i  (ad_s[s]),
      .byp_i (byp_s[s]),
      .ctl_o (ctl_s[s+1]),
      .r_o   (r_s[s+1]),
      .nq_o  (nq_s[s+1]),
      .ad_o  (ad_s[s+1]),
      .byp_o (byp_s[s+1])
    );
  end

  // result select, quotient clamp and sign
  always_comb begin
    cf      = ctl_s[QB];
    sat_nxt = cf.dir ? cf.sat_d : 1'b0;
    lsat    = 1'b0;
    for (int j = 0; j < 3; j++) begin
      lsat = cf.ovf[j] ||
             (cf.neg[j] ? (nq_s[QB][j] > {1'b1, {(QB-1){1'b0}}}) : nq_s[QB][j][QB-1]);
      if (cf.dir) begin
        res_nxt[j] = byp_s[QB][j];
      end else if (cf.wz) begin
        res_nxt[j] = '0;
      end else if (lsat) begin
        res_nxt[j] = cf.neg[j] ? {1'b1, {(hpt_pkg::DW-1){1'b0}}}
                               : {1'b0, {(hpt_pkg::DW-1){1'b1}}};
        sat_nxt    = 1'b1;
      end else begin
        res_nxt[j] = cf.neg[j] ? (~nq_s[QB][j] + 1'b1) : nq_s[QB][j];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (en[NST-1]) begin
      res_r <= res_nxt;
      wz_r  <= cf.wz && !cf.dir;
      sat_r <= sat_nxt;
    end
  end

  assign out_valid     = v_r[NST-1];
  assign out_x         = res_r[0];
  assign out_y         = res_r[1];
  assign out_z         = res_r[2];
  assign out_w_zero    = wz_r;
  assign out_saturated = sat_r;

  // checks
  a_wz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_w_zero |->
      out_x == '0 && out_y == '0 && out_z == '0 && !out_saturated)
    else $error("w_zero result with nonzero payload");

  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> v_r[0])
    else $error("accepted request not captured");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> v_r == '0)
    else $error("pipeline not empty after reset");

endmodule

[tb/homogeneous_point_transform_top_tb.sv]
// self-checking bench for the homogeneous point transform top level
module homogeneous_point_transform_top_tb;

  localparam int FB    = hpt_pkg::FRAC_BITS_DEF;
  localparam int LIMIT = 400000;
  localparam logic [63:0] ONE = 64'(1) << FB;

  // register indexes of the matrix rows
  typedef enum logic [hpt_pkg::IDX_W-1:0] {
    ROW0_LO, ROW0_HI, ROW1_LO, ROW1_HI, ROW2_LO, ROW2_HI, ROW3_LO, ROW3_HI
  } reg_idx_t;

  typedef struct {
    logic signed [31:0] x, y, z;
    logic               dir;
  } vec_req_t;

  typedef struct {
    logic signed [31:0] x, y, z;
    logic               wz, sat;
  } vec_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [hpt_pkg::IDX_W-1:0] cfg_index = '0;
  logic [hpt_pkg::REG_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [31:0] in_x = '0, in_y = '0, in_z = '0;
  logic in_is_direction = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] out_x, out_y, out_z;
  logic out_w_zero, out_saturated;

  homogeneous_point_transform_top dut (.*);

  // clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  logic [63:0] matrix_regs [hpt_pkg::NUM_REGS];
  vec_req_t    pending_reqs [$];
  vec_res_t    expected_res [$];
  int          fail_count = 0;
  int          cycle_count = 0;
  logic        in_took = 1'b0;
  logic        out_took = 1'b0;
  int          in_gap = 0;
  int          out_gap = 0;

  // matrix entry at row r, column c
  function automatic logic signed [63:0] mat_entry(int r, int c);
    logic [63:0] w;
    w = matrix_regs[r*2 + c/2];
    return (c % 2) ? 64'(signed'(w[63:32])) : 64'(signed'(w[31:0]));
  endfunction

  // clamp to 32-bit signed
  function automatic logic signed [31:0] clamp32(logic signed [63:0] v, ref bit sat);
    if (v > 64'sd2147483647) begin
      sat = 1'b1;
      return 32'sh7fffffff;
    end
    if (v < -64'sd2147483648) begin
      sat = 1'b1;
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  // (num << FB) / den truncated toward zero, then clamped
  function automatic logic signed [31:0] persp_div(logic signed [63:0] num,
                                                   logic signed [63:0] den, ref bit sat);
    logic signed [127:0] n, d, q;
    n = 128'(num) <<< FB;
    d = 128'(den);
    q = n / d;
    if (q > 128'sd2147483647) begin
      sat = 1'b1;
      return 32'sh7fffffff;
    end
    if (q < -128'sd2147483648) begin
      sat = 1'b1;
      return 32'sh80000000;
    end
    return q[31:0];
  endfunction

  // expected transform of one vector
  function automatic vec_res_t transform_vec(vec_req_t r);
    logic signed [63:0] v [3];
    logic signed [63:0] acc [4];
    logic signed [63:0] p;
    vec_res_t res;
    bit sat;
    sat = 1'b0;
    v[0] = 64'(r.x);
    v[1] = 64'(r.y);
    v[2] = 64'(r.z);
    for (int j = 0; j < 4; j++) begin
      acc[j] = 0;
      for (int i = 0; i < 3; i++) begin
        p = v[i] * mat_entry(i, j);
        acc[j] += p >>> FB;
      end
      if (!r.dir) acc[j] += mat_entry(3, j);
    end
    res.wz = 1'b0;
    if (r.dir) begin
      res.x = clamp32(acc[0], sat);
      res.y = clamp32(acc[1], sat);
      res.z = clamp32(acc[2], sat);
    end else if (acc[3] == 0) begin
      res.wz = 1'b1;
      res.x = 0;
      res.y = 0;
      res.z = 0;
    end else begin
      res.x = persp_div(acc[0], acc[3], sat);
      res.y = persp_div(acc[1], acc[3], sat);
      res.z = persp_div(acc[2], acc[3], sat);
    end
    res.sat = sat;
    return res;
  endfunction

  // random coordinate biased toward small and extreme values
  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(0, 6))
      0: return $urandom;
      1: return 32'sh7fffffff - $urandom_range(0, 3);
      2: return 32'sh80000000 + $urandom_range(0, 3);
      3: return 32'sh0;
      default: return $signed($urandom_range(0, 32'h000fffff)) - 32'sh00080000;
    endcase
  endfunction

  // random matrix entry, mostly moderate
  function automatic logic [31:0] rand_entry();
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return 32'h0;
      default: return $signed($urandom_range(0, 32'h0003ffff)) - 32'sh00020000;
    endcase
  endfunction

  // driver: holds each request until accepted, random gaps
  always @(negedge clk) begin
    vec_req_t rq;
    if (rst_n && (!in_valid || in_took)) begin
      if (in_gap > 0) begin
        in_valid <= 1'b0;
        in_gap   <= in_gap - 1;
      end else if (pending_reqs.size() > 0) begin
        rq = pending_reqs.pop_front();
        in_x            <= rq.x;
        in_y            <= rq.y;
        in_z            <= rq.z;
        in_is_direction <= rq.dir;
        in_valid        <= 1'b1;
        in_gap          <= $urandom_range(0, 8);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: random stall after each result
  always @(negedge clk) begin
    int g;
    if (out_took) begin
      g = $urandom_range(0, 8);
      if (g == 0) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b0;
        out_gap   <= g - 1;
      end
    end else if (out_gap > 0) begin
      out_ready <= 1'b0;
      out_gap   <= out_gap - 1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // monitor: predict on request, compare on result
  always @(posedge clk) begin
    vec_req_t rq;
    vec_res_t ex;
    cycle_count <= cycle_count + 1;
    in_took     <= rst_n && in_valid && in_ready;
    out_took    <= rst_n && out_valid && out_ready;
    if (rst_n && in_valid && in_ready) begin
      rq.x   = in_x;
      rq.y   = in_y;
      rq.z   = in_z;
      rq.dir = in_is_direction;
      expected_res.push_back(transform_vec(rq));
    end
    if (rst_n && out_valid && out_ready) begin
      if (expected_res.size() == 0) begin
        $error("result with no pending request");
        fail_count++;
      end else begin
        ex = expected_res.pop_front();
        if (out_x !== ex.x) begin
          $error("out_x expected %0d actual %0d", ex.x, out_x);
          fail_count++;
        end
        if (out_y !== ex.y) begin
          $error("out_y expected %0d actual %0d", ex.y, out_y);
          fail_count++;
        end
        if (out_z !== ex.z) begin
          $error("out_z expected %0d actual %0d", ex.z, out_z);
          fail_count++;
        end
        if (out_w_zero !== ex.wz) begin
          $error("out_w_zero expected %0d actual %0d", ex.wz, out_w_zero);
          fail_count++;
        end
        if (out_saturated !== ex.sat) begin
          $error("out_saturated expected %0d actual %0d", ex.sat, out_saturated);
          fail_count++;
        end
      end
    end
    if (cycle_count > LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // one register write, mirrored into the model
  task automatic write_reg(reg_idx_t idx, logic [63:0] val);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    matrix_regs[idx] = val;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic load_matrix(logic [63:0] m [8]);
    write_reg(ROW0_LO, m[0]);
    write_reg(ROW0_HI, m[1]);
    write_reg(ROW1_LO, m[2]);
    write_reg(ROW1_HI, m[3]);
    write_reg(ROW2_LO, m[4]);
    write_reg(ROW2_HI, m[5]);
    write_reg(ROW3_LO, m[6]);
    write_reg(ROW3_HI, m[7]);
  endtask

  // wait until every request has been answered
  task automatic wait_idle();
    @(posedge clk);
    while (pending_reqs.size() != 0 || in_valid || expected_res.size() != 0)
      @(posedge clk);
  endtask

  task automatic add_items(int n, int dir_pct);
    vec_req_t rq;
    for (int i = 0; i < n; i++) begin
      rq.x   = rand_coord();
      rq.y   = rand_coord();
      rq.z   = rand_coord();
      rq.dir = ($urandom_range(0, 99) < dir_pct);
      pending_reqs.push_back(rq);
    end
  endtask

  // stimulus: reset matrix first, then loaded matrices
  initial begin
    logic [63:0] m [8];
    matrix_regs[ROW0_LO] = ONE;
    matrix_regs[ROW0_HI] = '0;
    matrix_regs[ROW1_LO] = ONE << 32;
    matrix_regs[ROW1_HI] = '0;
    matrix_regs[ROW2_LO] = '0;
    matrix_regs[ROW2_HI] = ONE;
    matrix_regs[ROW3_LO] = '0;
    matrix_regs[ROW3_HI] = ONE << 32;
    rst_n = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // identity after reset
    add_items(100, 30);
    wait_idle();

    // random matrices
    for (int k = 0; k < 4; k++) begin
      for (int i = 0; i < 8; i++) m[i] = {rand_entry(), rand_entry()};
      load_matrix(m);
      add_items(100, 30);
      wait_idle();
    end

    // perspective matrix, w taken from z
    m[0] = ONE;
    m[1] = '0;
    m[2] = ONE << 32;
    m[3] = '0;
    m[4] = '0;
    m[5] = (ONE << 32) | ONE;
    m[6] = {rand_entry(), rand_entry()};
    m[7] = {32'h0, rand_entry()};
    load_matrix(m);
    add_items(60, 20);
    wait_idle();

    // column 3 all zero, w is zero for every point
    for (int i = 0; i < 8; i++) m[i] = {32'h0, rand_entry()};
    load_matrix(m);
    add_items(40, 25);
    wait_idle();

    repeat (4) @(posedge clk);
    if (fail_count == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
